// ===== src/sbus_frame_decoder_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sbf_pkg.sv =====
package sbf_pkg;

  localparam int WIN_LEN      = 25;
  localparam int CH_W         = 11;
  localparam int NUM_CH       = 10;
  localparam int DATA_BYTES   = 14;
  localparam int DATA_W       = DATA_BYTES * 8;
  localparam int CNT_W        = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 11;

  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam logic [7:0] TRL_BYTE = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_OFFSET = 3'd0,
    CFG_VALID_LIMIT   = 3'd1,
    CFG_DEADBAND      = 3'd2,
    CFG_SWITCH_LOW    = 3'd3,
    CFG_SWITCH_HIGH   = 3'd4,
    CFG_TOGGLE_LIMIT  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [10:0] center_offset;
    logic [10:0] valid_limit;
    logic [9:0]  deadband;
    logic [10:0] switch_low_limit;
    logic [10:0] switch_high_limit;
    logic [10:0] toggle_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_offset:     11'd992,
    valid_limit:       11'd800,
    deadband:          10'd25,
    switch_low_limit:  11'd500,
    switch_high_limit: 11'd1500,
    toggle_limit:      11'd1000
  };

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } frame_t;

  typedef struct packed {
    logic signed [11:0] right_horizontal;
    logic signed [11:0] right_vertical;
    logic signed [11:0] left_vertical;
    logic signed [11:0] left_horizontal;
    logic signed [11:0] knob_a;
    logic signed [11:0] knob_b;
    logic [1:0]         function_switch;
    logic [1:0]         mode_switch;
    logic               imu_switch;
    logic               gait_switch;
    logic               frame_valid;
  } result_t;

endpackage

// ===== src/sbf_framer.sv =====
`include "sbus_frame_decoder_macros.svh"

module sbf_framer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_chunk_start,
  input  logic            dn_ready,
  output sbf_pkg::frame_t frame
);
  import sbf_pkg::*;

  logic [7:0]       win_r [WIN_LEN];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_base;
  logic             matched_r, matched_nxt, matched_base;
  logic             frm_valid_r, frm_valid_nxt;
  logic [DATA_W-1:0] frm_data_r, frm_data_nxt;
  logic             accept, hit;

  assign in_stall = frm_valid_r && !dn_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cnt_base     = in_chunk_start ? '0 : cnt_r;
    matched_base = in_chunk_start ? 1'b0 : matched_r;
    cnt_nxt      = (cnt_base < CNT_W'(WIN_LEN)) ? cnt_base + CNT_W'(1) : cnt_base;
    hit          = (cnt_nxt == CNT_W'(WIN_LEN)) && !matched_base &&
                   (win_r[1] == HDR_BYTE) && (in_data_byte == TRL_BYTE);
    matched_nxt  = matched_base || hit;
    for (int i = 0; i < DATA_BYTES; i++) begin
      frm_data_nxt[i*8 +: 8] = win_r[i+2];
    end
    if (accept) begin
      frm_valid_nxt = hit;
    end else if (dn_ready) begin
      frm_valid_nxt = 1'b0;
    end else begin
      frm_valid_nxt = frm_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_LEN-1] <= in_data_byte;
      if (hit) begin
        frm_data_r <= frm_data_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      matched_r   <= 1'b0;
      frm_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r     <= cnt_nxt;
        matched_r <= matched_nxt;
      end
      frm_valid_r <= frm_valid_nxt;
    end
  end

  assign frame.valid = frm_valid_r;
  assign frame.data  = frm_data_r;

  `SBF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(WIN_LEN), "byte count past window length")
  `SBF_ASSERT_NEXT(a_hit_marks, accept && hit, frm_valid_r && matched_r, "match not captured")
  `SBF_ASSERT_NOW(a_frame_full, frm_valid_r, cnt_r == CNT_W'(WIN_LEN), "frame from short chunk")

endmodule

// ===== src/sbf_decoder.sv =====
`include "sbus_frame_decoder_macros.svh"

module sbf_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  sbf_pkg::cfg_t    cfg,
  input  sbf_pkg::frame_t  frame,
  output logic             dn_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output sbf_pkg::result_t res
);
  import sbf_pkg::*;

  function automatic logic signed [11:0] centre(logic [10:0] r, logic [10:0] o);
    return $signed({1'b0, r}) - $signed({1'b0, o});
  endfunction

  function automatic logic beyond(logic signed [11:0] x, logic [10:0] lim);
    logic signed [12:0] x13;
    logic signed [12:0] l13;
    x13 = {x[11], x};
    l13 = $signed({2'b00, lim});
    return (x13 > l13) || (x13 < -l13);
  endfunction

  function automatic logic signed [11:0] dead(logic signed [11:0] x, logic [9:0] db);
    logic signed [12:0] x13;
    logic signed [12:0] d13;
    x13 = {x[11], x};
    d13 = $signed({3'b000, db});
    return ((x13 > -d13) && (x13 < d13)) ? 12'sd0 : x;
  endfunction

  function automatic logic [1:0] three_pos(logic [10:0] r, logic [10:0] lo, logic [10:0] hi);
    if (r > hi) return 2'd3;
    if (r < lo) return 2'd1;
    return 2'd2;
  endfunction

  logic [CH_W-1:0]    raw [NUM_CH];
  logic signed [11:0] rh, rv, lv, lh, ka, kb;
  logic               bad;
  result_t            res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign dn_ready = !out_valid_r || !out_stall;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      raw[k] = frame.data[k*CH_W +: CH_W];
    end
    rh  = centre(raw[0], cfg.center_offset);
    rv  = centre(raw[1], cfg.center_offset);
    lv  = centre(raw[2], cfg.center_offset);
    lh  = centre(raw[3], cfg.center_offset);
    ka  = centre(raw[8], cfg.center_offset);
    kb  = centre(raw[9], cfg.center_offset);
    bad = beyond(rh, cfg.valid_limit) || beyond(rv, cfg.valid_limit) ||
          beyond(lv, cfg.valid_limit) || beyond(lh, cfg.valid_limit);
    res_nxt = '0;
    if (!bad) begin
      res_nxt.right_horizontal = dead(rh, cfg.deadband);
      res_nxt.right_vertical   = dead(rv, cfg.deadband);
      res_nxt.left_vertical    = dead(lv, cfg.deadband);
      res_nxt.left_horizontal  = dead(lh, cfg.deadband);
      res_nxt.knob_a           = ka;
      res_nxt.knob_b           = kb;
      res_nxt.function_switch  = three_pos(raw[4], cfg.switch_low_limit,
                                           cfg.switch_high_limit);
      res_nxt.mode_switch      = three_pos(raw[7], cfg.switch_low_limit,
                                           cfg.switch_high_limit);
      res_nxt.imu_switch       = !(raw[5] > cfg.toggle_limit);
      res_nxt.gait_switch      = !(raw[6] > cfg.toggle_limit);
      res_nxt.frame_valid      = 1'b1;
    end
    out_valid_nxt = dn_ready ? frame.valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (dn_ready && frame.valid) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  `SBF_ASSERT_NOW(a_invalid_zero, out_valid_r && !res_r.frame_valid, res_r == '0, "invalid frame not zeroed")
  `SBF_ASSERT_NOW(a_switch_live, out_valid_r && res_r.frame_valid, res_r.function_switch != 2'd0 && res_r.mode_switch != 2'd0, "switch decoded as zero")

endmodule

// ===== src/sbus_frame_decoder.sv =====
// channel   | handshake               | beat
// in_       | in_valid / in_stall     | data_byte, chunk_start
// out_      | out_valid / out_stall   | decoded channels, frame_valid
// cfg_      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One byte is taken per cycle unless stalled; the window shift and header/
// trailer match run in the accept cycle, the channel decode registers the
// result once the decoder is ready. Reset (rst_n low, synchronous) clears the
// byte count, chunk match flag, valid flags and loads the register defaults.
// A stall on out_ holds the result; in_stall rises once a matched frame waits.
module sbus_frame_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_chunk_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [11:0]               out_right_horizontal,
  output logic signed [11:0]               out_right_vertical,
  output logic signed [11:0]               out_left_vertical,
  output logic signed [11:0]               out_left_horizontal,
  output logic signed [11:0]               out_knob_a,
  output logic signed [11:0]               out_knob_b,
  output logic [1:0]                       out_function_switch,
  output logic [1:0]                       out_mode_switch,
  output logic                             out_imu_switch,
  output logic                             out_gait_switch,
  output logic                             out_frame_valid,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sbf_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  frame_t  frame;
  result_t res;
  logic    dn_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_OFFSET: cfg_nxt.center_offset     = cfg_data;
        CFG_VALID_LIMIT:   cfg_nxt.valid_limit       = cfg_data;
        CFG_DEADBAND:      cfg_nxt.deadband          = cfg_data[9:0];
        CFG_SWITCH_LOW:    cfg_nxt.switch_low_limit  = cfg_data;
        CFG_SWITCH_HIGH:   cfg_nxt.switch_high_limit = cfg_data;
        CFG_TOGGLE_LIMIT:  cfg_nxt.toggle_limit      = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sbf_framer u_framer (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_chunk_start (in_chunk_start),
    .dn_ready       (dn_ready),
    .frame          (frame)
  );

  sbf_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .frame     (frame),
    .dn_ready  (dn_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_right_horizontal = res.right_horizontal;
  assign out_right_vertical   = res.right_vertical;
  assign out_left_vertical    = res.left_vertical;
  assign out_left_horizontal  = res.left_horizontal;
  assign out_knob_a           = res.knob_a;
  assign out_knob_b           = res.knob_b;
  assign out_function_switch  = res.function_switch;
  assign out_mode_switch      = res.mode_switch;
  assign out_imu_switch       = res.imu_switch;
  assign out_gait_switch      = res.gait_switch;
  assign out_frame_valid      = res.frame_valid;

endmodule

// ===== bench/tb_sbus_frame_decoder.sv =====
`timescale 1ns / 100ps

module tb_sbus_frame_decoder;
  import sbf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam logic [1:0] SW_UP   = 2'd1;
  localparam logic [1:0] SW_MID  = 2'd2;
  localparam logic [1:0] SW_DOWN = 2'd3;
  localparam int MAX_WAIT     = 9;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {INTACT, BAD_HEADER, BAD_TRAILER, SPLIT_CHUNK} frame_damage_t;
  typedef logic [NUM_CH-1:0][CH_W-1:0] chan_set_t;
  typedef struct {
    logic [7:0] data;
    logic       start;
    int         gap;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic in_chunk_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [11:0] out_right_horizontal;
  logic signed [11:0] out_right_vertical;
  logic signed [11:0] out_left_vertical;
  logic signed [11:0] out_left_horizontal;
  logic signed [11:0] out_knob_a;
  logic signed [11:0] out_knob_b;
  logic [1:0] out_function_switch;
  logic [1:0] out_mode_switch;
  logic out_imu_switch;
  logic out_gait_switch;
  logic out_frame_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sbus_frame_decoder dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_chunk_start       (in_chunk_start),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_right_horizontal (out_right_horizontal),
    .out_right_vertical   (out_right_vertical),
    .out_left_vertical    (out_left_vertical),
    .out_left_horizontal  (out_left_horizontal),
    .out_knob_a           (out_knob_a),
    .out_knob_b           (out_knob_b),
    .out_function_switch  (out_function_switch),
    .out_mode_switch      (out_mode_switch),
    .out_imu_switch       (out_imu_switch),
    .out_gait_switch      (out_gait_switch),
    .out_frame_valid      (out_frame_valid),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #10 clk = ~clk;

  cfg_t model_cfg;
  logic [7:0] win_bytes [WIN_LEN];
  int win_fill;
  bit win_matched;
  result_t decoded_frames [$];
  beat_t beat_queue [$];
  int beats_made = 0;
  int mismatches = 0;

  beat_t next_beat;
  bit have_next = 1'b0;
  int gap_left = 0;

  int stall_left = 0;
  bit recv_calm = 1'b0;
  logic recv_blocked = 1'b0;
  bit long_hold_req = 1'b0;
  result_t got_frame;
  result_t want_frame;

  function automatic logic [1:0] three_way(input logic [CH_W-1:0] raw);
    if (raw > model_cfg.switch_high_limit) return SW_DOWN;
    if (raw < model_cfg.switch_low_limit) return SW_UP;
    return SW_MID;
  endfunction

  task automatic decode_sbus_byte(input logic [7:0] b, input logic start);
    logic [DATA_W-1:0] payload;
    chan_set_t raw;
    int x [4];
    int lim, db, i;
    bit wild;
    result_t r;
    if (start) begin
      win_fill = 0;
      win_matched = 1'b0;
    end
    for (i = 0; i < WIN_LEN - 1; i++) win_bytes[i] = win_bytes[i + 1];
    win_bytes[WIN_LEN - 1] = b;
    if (win_fill < WIN_LEN) win_fill++;
    if (win_fill == WIN_LEN && !win_matched && win_bytes[0] == HDR_BYTE &&
        win_bytes[WIN_LEN - 1] == TRL_BYTE) begin
      win_matched = 1'b1;
      for (i = 0; i < DATA_BYTES; i++) payload[8*i +: 8] = win_bytes[i + 1];
      raw = payload[NUM_CH*CH_W-1:0];
      lim = model_cfg.valid_limit;
      db = model_cfg.deadband;
      wild = 1'b0;
      for (i = 0; i < 4; i++) begin
        x[i] = int'(raw[i]) - int'(model_cfg.center_offset);
        if (x[i] > lim || x[i] < -lim) wild = 1'b1;
        if (x[i] > -db && x[i] < db) x[i] = 0;
      end
      r = '0;
      if (!wild) begin
        r.right_horizontal = 12'(x[0]);
        r.right_vertical = 12'(x[1]);
        r.left_vertical = 12'(x[2]);
        r.left_horizontal = 12'(x[3]);
        r.knob_a = 12'(int'(raw[8]) - int'(model_cfg.center_offset));
        r.knob_b = 12'(int'(raw[9]) - int'(model_cfg.center_offset));
        r.function_switch = three_way(raw[4]);
        r.mode_switch = three_way(raw[7]);
        r.imu_switch = (raw[5] > model_cfg.toggle_limit) ? 1'b0 : 1'b1;
        r.gait_switch = (raw[6] > model_cfg.toggle_limit) ? 1'b0 : 1'b1;
        r.frame_valid = 1'b1;
      end
      decoded_frames.push_back(r);
    end
  endtask

  task automatic show_frame(input string tag, input result_t r);
    $display("  %s: rh=%0d rv=%0d lv=%0d lh=%0d ka=%0d kb=%0d fn=%0d md=%0d imu=%0d gait=%0d v=%0d",
             tag, r.right_horizontal, r.right_vertical, r.left_vertical, r.left_horizontal,
             r.knob_a, r.knob_b, r.function_switch, r.mode_switch, r.imu_switch,
             r.gait_switch, r.frame_valid);
  endtask

  // driver: present one beat at a time, honoring each beat's drawn gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || !in_stall) begin
        if (in_valid) decode_sbus_byte(in_data_byte, in_chunk_start);
        if (!have_next && beat_queue.size() > 0) begin
          next_beat = beat_queue.pop_front();
          have_next = 1'b1;
          gap_left = next_beat.gap;
        end
        if (have_next && gap_left == 0) begin
          in_valid <= 1'b1;
          in_data_byte <= next_beat.data;
          in_chunk_start <= next_beat.start;
          have_next = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // monitor: check each accepted result beat, then draw the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_frame = {out_right_horizontal, out_right_vertical, out_left_vertical,
                     out_left_horizontal, out_knob_a, out_knob_b, out_function_switch,
                     out_mode_switch, out_imu_switch, out_gait_switch, out_frame_valid};
        if (decoded_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] result with no frame pending", $time);
            show_frame("got ", got_frame);
          end
        end else begin
          want_frame = decoded_frames.pop_front();
          if (got_frame !== want_frame) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] decoded frame mismatch", $time);
              show_frame("want", want_frame);
              show_frame("got ", got_frame);
            end
          end
        end
        stall_left = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= recv_blocked || (stall_left > 0);
    end
  end

  // hold the receiver off for a long stretch once requested
  initial begin
    wait (long_hold_req);
    @(posedge clk);
    recv_blocked <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    recv_blocked <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_beat(input logic [7:0] data, input logic start, input bit calm);
    beat_t bt;
    bt.data = data;
    bt.start = start;
    bt.gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    beat_queue.push_back(bt);
    beats_made++;
  endtask

  task automatic push_noise(input int n, input bit first_start, input bit scatter,
                            input bit calm);
    int i;
    for (i = 0; i < n; i++)
      push_beat(8'($urandom), scatter ? ($urandom_range(0, 7) == 0) : (first_start && i == 0),
                calm);
  endtask

  function automatic logic [CH_W-1:0] stick_raw();
    int lim, db, d;
    lim = model_cfg.valid_limit;
    db = model_cfg.deadband;
    case ($urandom_range(0, 23))
      0: d = lim;
      1: d = -lim;
      2: d = lim + 1;
      3: d = -lim - 1;
      4: d = db;
      5: d = -db;
      6: d = db - 1;
      7: d = 1 - db;
      8: d = 0;
      9: return 11'($urandom_range(0, 2047));
      default: d = int'($urandom_range(0, 2 * lim)) - lim;
    endcase
    return 11'(int'(model_cfg.center_offset) + d);
  endfunction

  function automatic logic [CH_W-1:0] near_raw(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
    case ($urandom_range(0, 8))
      0: return a - 11'd1;
      1: return a;
      2: return a + 11'd1;
      3: return b - 11'd1;
      4: return b;
      5: return b + 11'd1;
      6: return 11'd0;
      7: return 11'h7FF;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic chan_set_t random_channels();
    chan_set_t ch;
    int k;
    for (k = 0; k < 4; k++) ch[k] = stick_raw();
    ch[4] = near_raw(model_cfg.switch_low_limit, model_cfg.switch_high_limit);
    ch[5] = near_raw(model_cfg.toggle_limit, model_cfg.toggle_limit);
    ch[6] = near_raw(model_cfg.toggle_limit, model_cfg.toggle_limit);
    ch[7] = near_raw(model_cfg.switch_low_limit, model_cfg.switch_high_limit);
    ch[8] = near_raw(model_cfg.center_offset, model_cfg.center_offset);
    ch[9] = near_raw(model_cfg.center_offset, model_cfg.center_offset);
    return ch;
  endfunction

  task automatic push_frame(input chan_set_t ch, input bit first_start, input bit calm,
                            input frame_damage_t damage);
    logic [7:0] frm [WIN_LEN];
    logic starts [WIN_LEN];
    logic [127:0] bits;
    int i;
    bits = {$urandom, $urandom, $urandom, $urandom};
    bits[NUM_CH*CH_W-1:0] = ch;
    frm[0] = HDR_BYTE;
    for (i = 0; i < DATA_BYTES; i++) frm[i + 1] = bits[8*i +: 8];
    for (i = DATA_BYTES + 1; i < WIN_LEN - 1; i++) frm[i] = 8'($urandom);
    frm[WIN_LEN - 1] = TRL_BYTE;
    for (i = 0; i < WIN_LEN; i++) starts[i] = 1'b0;
    starts[0] = first_start;
    case (damage)
      BAD_HEADER: frm[0] = HDR_BYTE ^ 8'($urandom_range(1, 255));
      BAD_TRAILER: frm[WIN_LEN - 1] = 8'($urandom_range(1, 255));
      SPLIT_CHUNK: starts[$urandom_range(1, WIN_LEN - 1)] = 1'b1;
      default: ;
    endcase
    for (i = 0; i < WIN_LEN; i++) push_beat(frm[i], starts[i], calm);
  endtask

  task automatic run_traffic(input int n);
    int stop;
    bit calm;
    stop = beats_made + n;
    while (beats_made < stop) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          push_frame(random_channels(), 1'b1, calm, INTACT);
          if ($urandom_range(0, 3) == 0) push_frame(random_channels(), 1'b0, calm, INTACT);
          if ($urandom_range(0, 2) == 0) push_noise($urandom_range(1, 10), 1'b0, 1'b0, calm);
        end
        6: begin
          push_noise($urandom_range(1, 20), 1'b1, 1'b0, calm);
          push_frame(random_channels(), 1'b0, calm, INTACT);
        end
        7: begin
          push_beat(HDR_BYTE, 1'b1, calm);
          push_noise($urandom_range(0, WIN_LEN - 3), 1'b0, 1'b0, calm);
          push_beat(TRL_BYTE, 1'b0, calm);
        end
        8: push_frame(random_channels(), 1'b1, calm, frame_damage_t'($urandom_range(1, 3)));
        default: push_noise($urandom_range(1, 30), 1'b0, 1'b1, calm);
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (beat_queue.size() != 0 || have_next || in_valid || decoded_frames.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CENTER_OFFSET: model_cfg.center_offset = val;
      CFG_VALID_LIMIT:   model_cfg.valid_limit = val;
      CFG_DEADBAND:      model_cfg.deadband = val[9:0];
      CFG_SWITCH_LOW:    model_cfg.switch_low_limit = val;
      CFG_SWITCH_HIGH:   model_cfg.switch_high_limit = val;
      CFG_TOGGLE_LIMIT:  model_cfg.toggle_limit = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [10:0] co, input logic [10:0] vl, input logic [10:0] db,
                           input logic [10:0] sl, input logic [10:0] sh, input logic [10:0] tl);
    write_reg(CFG_CENTER_OFFSET, co);
    write_reg(CFG_VALID_LIMIT, vl);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_SWITCH_LOW, sl);
    write_reg(CFG_SWITCH_HIGH, sh);
    write_reg(CFG_TOGGLE_LIMIT, tl);
  endtask

  initial begin
    chan_set_t ch;
    model_cfg = CFG_RESET;
    for (int i = 0; i < WIN_LEN; i++) win_bytes[i] = 8'h00;
    win_fill = 0;
    win_matched = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // short chunk, then one frame on the reset settings' boundaries, then random traffic
    push_beat(HDR_BYTE, 1'b1, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(TRL_BYTE, 1'b0, 1'b0);
    ch[0] = CFG_RESET.center_offset + CFG_RESET.valid_limit;
    ch[1] = CFG_RESET.center_offset - CFG_RESET.valid_limit;
    ch[2] = CFG_RESET.center_offset + CFG_RESET.deadband;
    ch[3] = CFG_RESET.center_offset - CFG_RESET.deadband + 11'd1;
    ch[4] = CFG_RESET.switch_low_limit - 11'd1;
    ch[5] = CFG_RESET.toggle_limit;
    ch[6] = CFG_RESET.toggle_limit + 11'd1;
    ch[7] = CFG_RESET.switch_high_limit + 11'd1;
    ch[8] = 11'd0;
    ch[9] = 11'h7FF;
    push_frame(ch, 1'b1, 1'b0, INTACT);
    run_traffic(480);
    wait_drained();

    // swapped switch limits, widest stick range, writes to the spare indices
    write_all(11'd0, 11'h7FF, 11'd0, 11'h7FF, 11'd0, 11'd0);
    write_reg(CFG_SPARE_6, 11'h7FF);
    write_reg(CFG_SPARE_7, 11'h2AA);
    run_traffic(250);
    wait_drained();

    // deadband write exercises the dropped top bit
    write_all(11'h7FF, 11'd0, 11'h7FF, 11'd0, 11'h7FF, 11'h7FF);
    run_traffic(250);
    wait_drained();

    write_all(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
              11'($urandom_range(0, 1023)), 11'($urandom_range(0, 2047)),
              11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
    long_hold_req = 1'b1;
    repeat (12) push_frame(random_channels(), 1'b1, 1'b1, INTACT);
    run_traffic(100);
    wait_drained();

    write_all(11'($urandom_range(900, 1100)), 11'($urandom_range(300, 1000)),
              11'($urandom_range(0, 200)), 11'($urandom_range(200, 900)),
              11'($urandom_range(1100, 1900)), 11'($urandom_range(500, 1500)));
    run_traffic(250);
    wait_drained();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
